// ===== design/kpdc_pkg.sv =====
// Shared types, constants and register map of the key press duration classifier.
package kpdc_pkg;

    localparam int NumKeys   = 3;
    localparam int KeySlots  = 3;
    localparam int NumRegs   = 8;
    localparam int CntW      = 13;
    localparam int StateW    = 3;
    localparam int CountW    = 2;
    localparam int AddrW     = 5;
    localparam int DataW     = 32;
    localparam int InTdataW  = 8;
    localparam int OutTdataW = 16;

    localparam logic [CntW-1:0] HoldMax = CntW'(8000);

    typedef enum logic [StateW-1:0] {
        KC_IDLE    = 3'd0,
        KC_CLICK   = 3'd1,
        KC_HELD2S  = 3'd2,
        KC_HELD4S  = 3'd3,
        KC_HELD6S  = 3'd4,
        KC_HELD7S  = 3'd5,
        KC_HELD8S  = 3'd6,
        KC_HELD12S = 3'd7
    } t_key_class;

    typedef enum logic [2:0] {
        REG_CLICK  = 3'd0,
        REG_HOLD2  = 3'd1,
        REG_HOLD4  = 3'd2,
        REG_HOLD5  = 3'd3,
        REG_HOLD6  = 3'd4,
        REG_HOLD7  = 3'd5,
        REG_HOLD8  = 3'd6,
        REG_HOLD12 = 3'd7
    } t_reg_idx;

    typedef logic [CntW-1:0] t_thresh [NumRegs];

    typedef struct packed {
        t_key_class state;
        logic       held5s;
    } t_key_status;

    localparam logic [CntW-1:0] RegReset [NumRegs] = '{
        CntW'(2), CntW'(200), CntW'(400), CntW'(500),
        CntW'(600), CntW'(700), CntW'(800), CntW'(1200)
    };

endpackage

// ===== design/kpdc_lane.sv =====
// One key lane: hold counter, threshold compares and class state.
module kpdc_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_level,
    input  kpdc_pkg::t_thresh    i_thresh,
    output kpdc_pkg::t_key_status o_next
);
    import kpdc_pkg::*;

    logic [CntW-1:0] r_cnt, n_cnt;
    t_key_class      r_state, n_state;
    logic            r_held5s, n_held5s;

    always_comb begin
        n_cnt    = '0;
        n_state  = KC_IDLE;
        n_held5s = 1'b0;
        if (!i_level) begin
            n_cnt    = (r_cnt >= HoldMax - CntW'(1)) ? HoldMax : r_cnt + CntW'(1);
            n_state  = r_state;
            n_held5s = r_held5s;
            if (n_cnt == i_thresh[REG_CLICK])  n_state  = KC_CLICK;
            if (n_cnt == i_thresh[REG_HOLD2])  n_state  = KC_HELD2S;
            if (n_cnt == i_thresh[REG_HOLD4])  n_state  = KC_HELD4S;
            if (n_cnt == i_thresh[REG_HOLD5])  n_held5s = 1'b1;
            if (n_cnt == i_thresh[REG_HOLD6])  n_state  = KC_HELD6S;
            if (n_cnt == i_thresh[REG_HOLD7])  n_state  = KC_HELD7S;
            if (n_cnt == i_thresh[REG_HOLD8])  n_state  = KC_HELD8S;
            if (n_cnt == i_thresh[REG_HOLD12]) n_state  = KC_HELD12S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_state  <= KC_IDLE;
            r_held5s <= 1'b0;
        end else if (i_accept) begin
            r_cnt    <= n_cnt;
            r_state  <= n_state;
            r_held5s <= n_held5s;
        end
    end

    assign o_next.state  = n_state;
    assign o_next.held5s = n_held5s;

endmodule

// ===== design/kpdc_merge.sv =====
// Merge stage: count active keys and pack the result item.
module kpdc_merge (
    input  kpdc_pkg::t_key_status         i_status [kpdc_pkg::KeySlots],
    output logic [kpdc_pkg::OutTdataW-1:0] o_tdata
);
    import kpdc_pkg::*;

    logic [CountW-1:0] count;

    always_comb begin
        count = '0;
        for (int k = 0; k < KeySlots; k++) begin
            if (i_status[k].state != KC_IDLE || i_status[k].held5s)
                count = count + CountW'(1);
        end
    end

    assign o_tdata = {2'b00, count,
                      i_status[2].held5s, i_status[1].held5s, i_status[0].held5s,
                      i_status[2].state, i_status[1].state, i_status[0].state};

endmodule

// ===== design/key_press_duration_classifier.sv =====
// Top level of the key press duration classifier: config registers, lanes, output register.
//
// Usage:
//   Input channel s_*: one item per scan tick; s_tdata[2:0] carries the raw
//   level of keys 0..2 (low means pressed), upper bits are ignored.
//   Output channel m_*: one item per input item, in order. m_tdata fields
//   from bit 0 up: key0_state[2:0], key1_state[5:3], key2_state[8:6],
//   key0_held5s[9], key1_held5s[10], key2_held5s[11], active_key_count[13:12].
//   Configuration: APB port, eight 13-bit thresholds at byte address 4*i
//   (click, 2s, 4s, 5s, 6s, 7s, 8s, 12s); write only while idle.
//   The result appears on m_tvalid in the cycle after the item is
//   accepted. Throughput: one item per cycle while m_tready is high, set by the
//   single output register; all key lanes update in parallel in the accepting cycle.
//   Stall: while m_tready is low and the output register is full, s_tready
//   drops and lane state holds; the output item holds until taken.
//   Reset (i_rst_n low, synchronous): counters, states and flags clear,
//   thresholds return to their defaults, the output register empties.
module key_press_duration_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [kpdc_pkg::InTdataW-1:0]        s_tdata,  // [2:0] key_levels
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [2:0] key0_state, [5:3] key1_state, [8:6] key2_state, [9] key0_held5s,
    // [10] key1_held5s, [11] key2_held5s, [13:12] active_key_count
    output logic [kpdc_pkg::OutTdataW-1:0]       m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kpdc_pkg::AddrW-1:0]           paddr,
    input  logic [kpdc_pkg::DataW-1:0]           pwdata,
    output logic [kpdc_pkg::DataW-1:0]           prdata,
    output logic                                 pready
);
    import kpdc_pkg::*;

    t_thresh                r_thresh;
    logic                   r_out_valid;
    logic [OutTdataW-1:0]   r_out_data;
    logic                   accept;
    t_key_status            lane_next [KeySlots];
    logic [OutTdataW-1:0]   merged;
    logic [2:0]             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrW-1:2];
    assign prdata  = {{(DataW-CntW){1'b0}}, r_thresh[reg_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= RegReset;
        end else if (psel && penable && pwrite) begin
            r_thresh[reg_idx] <= pwdata[CntW-1:0];
        end
    end

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    for (genvar k = 0; k < KeySlots; k++) begin : g_lane
        if (k < NumKeys) begin : g_live
            kpdc_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (accept),
                .i_level  (s_tdata[k]),
                .i_thresh (r_thresh),
                .o_next   (lane_next[k])
            );
        end else begin : g_unused
            assign lane_next[k] = '{state: KC_IDLE, held5s: 1'b0};
        end
    end

    kpdc_merge u_merge (
        .i_status (lane_next),
        .o_tdata  (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= merged;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule
